### rtl/swarm_pkg.sv
// ---------------------------------------------------------------------------
// swarm_pkg
// Shared widths, codes, reset values and payload types of the swarm block.
// ---------------------------------------------------------------------------
`default_nettype none

package swarm_pkg;

    localparam int POS_W      = 25;
    localparam int VEL_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int IDX_W      = 7;
    localparam int PCNT_W     = 8;
    localparam int NCNT_W     = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 25;
    localparam int DIST_W     = 51;
    localparam int KEY_W      = 2 * POS_W;

    localparam int DEF_MAX_PARTICLES  = 128;
    localparam int DEF_MAX_NEIGHBOURS = 16;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_PARTICLE_COUNT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NEIGHBOUR_COUNT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INERTIA_WEIGHT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COGNITIVE_GAIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SOCIAL_GAIN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_WORLD_WIDTH     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_WORLD_HEIGHT    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP       = 3'd7;

    localparam logic [PCNT_W-1:0] RST_PARTICLE_COUNT  = 8'd100;
    localparam logic [NCNT_W-1:0] RST_NEIGHBOUR_COUNT = 5'd10;
    localparam logic [GAIN_W-1:0] RST_INERTIA_WEIGHT  = 16'd14746;
    localparam logic [GAIN_W-1:0] RST_COGNITIVE_GAIN  = 16'd24576;
    localparam logic [GAIN_W-1:0] RST_SOCIAL_GAIN     = 16'd24576;
    localparam logic [POS_W-1:0]  RST_WORLD_WIDTH     = 25'd16384000;
    localparam logic [POS_W-1:0]  RST_WORLD_HEIGHT    = 25'd16384000;
    localparam logic [GAIN_W-1:0] RST_TIME_STEP       = 16'd655;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         part_idx;
        logic [POS_W-1:0]         load_pos_x;
        logic [POS_W-1:0]         load_pos_y;
        logic signed [VEL_W-1:0]  load_vel_x;
        logic signed [VEL_W-1:0]  load_vel_y;
        logic [GAIN_W-1:0]        rand_cognitive;
        logic [GAIN_W-1:0]        rand_social;
        logic [POS_W-1:0]         target_x;
        logic [POS_W-1:0]         target_y;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic [POS_W-1:0]         new_pos_x;
        logic [POS_W-1:0]         new_pos_y;
        logic signed [VEL_W-1:0]  new_vel_x;
        logic signed [VEL_W-1:0]  new_vel_y;
        logic                     best_improved;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic [POS_W-1:0] best_x;
        logic [POS_W-1:0] best_y;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic cand_valid;
        logic pick_start;
    } knn_ctrl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] inertia;
        logic [GAIN_W-1:0] cognitive;
        logic [GAIN_W-1:0] social;
        logic [POS_W-1:0]  width;
        logic [POS_W-1:0]  height;
        logic [GAIN_W-1:0] step;
    } tail_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [VEL_W-1:0]  vel_x;
        logic [VEL_W-1:0]  vel_y;
        logic [POS_W-1:0]  best_x;
        logic [POS_W-1:0]  best_y;
        logic [POS_W-1:0]  nb_x;
        logic [POS_W-1:0]  nb_y;
        logic [GAIN_W-1:0] r1;
        logic [GAIN_W-1:0] r2;
        logic [POS_W-1:0]  tgt_x;
        logic [POS_W-1:0]  tgt_y;
    } tail_op_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic             improved;
    } tail_res_t;

endpackage

`default_nettype wire

### rtl/swarm_store.sv
// ---------------------------------------------------------------------------
// swarm_store
// Particle state memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module swarm_store #(
    parameter int MAX_PARTICLES = swarm_pkg::DEF_MAX_PARTICLES,
    localparam int AW = $clog2(MAX_PARTICLES)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire swarm_pkg::entry_t wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output swarm_pkg::entry_t     rdata
);
    import swarm_pkg::*;

    entry_t mem [MAX_PARTICLES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/swarm_knn.sv
// ---------------------------------------------------------------------------
// swarm_knn
// Nearest-neighbour list: squared-distance pipe, sorted insertion list and
// a pass over the list that picks the entry nearest the target.
// ---------------------------------------------------------------------------
`default_nettype none

module swarm_knn #(
    parameter int MAX_NEIGHBOURS = swarm_pkg::DEF_MAX_NEIGHBOURS,
    localparam int NKW = $clog2(MAX_NEIGHBOURS + 1),
    localparam int NIW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire swarm_pkg::knn_ctrl_t        ctrl,
    input  wire logic [NKW-1:0]              nk,
    input  wire logic [swarm_pkg::POS_W-1:0] self_x,
    input  wire logic [swarm_pkg::POS_W-1:0] self_y,
    input  wire logic [swarm_pkg::POS_W-1:0] cand_x,
    input  wire logic [swarm_pkg::POS_W-1:0] cand_y,
    input  wire logic [swarm_pkg::POS_W-1:0] tgt_x,
    input  wire logic [swarm_pkg::POS_W-1:0] tgt_y,
    output logic                             busy,
    output logic                             pick_done,
    output logic [swarm_pkg::POS_W-1:0]      best_x,
    output logic [swarm_pkg::POS_W-1:0]      best_y
);
    import swarm_pkg::*;

    logic [MAX_NEIGHBOURS-1:0] valid_reg;
    logic [DIST_W-1:0]         dist_reg [MAX_NEIGHBOURS];
    logic [KEY_W-1:0]          key_reg  [MAX_NEIGHBOURS];
    logic [NKW-1:0]            nk_reg;
    logic [NKW-1:0]            cnt_reg;
    logic                      picking_reg;
    logic [NKW-1:0]            pick_i_reg;
    logic                      pick_done_reg;
    logic [KEY_W-1:0]          best_reg;
    logic [DIST_W-1:0]         fbest_reg;

    // distance pipe stage one
    logic                      v1_reg;
    logic                      mode1_reg;
    logic [NKW-1:0]            tag1_reg;
    logic [KEY_W-1:0]          key1_reg;
    logic [2*POS_W-1:0]        sqx_reg;
    logic [2*POS_W-1:0]        sqy_reg;

    logic                      issue_pick;
    logic [KEY_W-1:0]          cand_key;
    logic [KEY_W-1:0]          ref_key;
    logic signed [POS_W:0]     dx;
    logic signed [POS_W:0]     dy;
    logic signed [2*POS_W+1:0] sqx;
    logic signed [2*POS_W+1:0] sqy;
    logic [DIST_W-1:0]         dsum;
    logic                      insert;
    logic [MAX_NEIGHBOURS-1:0] ins_lt;

    assign issue_pick = picking_reg && (pick_i_reg < cnt_reg);
    assign cand_key   = picking_reg ? key_reg[pick_i_reg[NIW-1:0]] : {cand_x, cand_y};
    assign ref_key    = picking_reg ? {tgt_x, tgt_y} : {self_x, self_y};

    always_comb
    begin
        dx  = $signed({1'b0, cand_key[KEY_W-1:POS_W]}) - $signed({1'b0, ref_key[KEY_W-1:POS_W]});
        dy  = $signed({1'b0, cand_key[POS_W-1:0]}) - $signed({1'b0, ref_key[POS_W-1:0]});
        sqx = dx * dx;
        sqy = dy * dy;
    end

    assign dsum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign insert = v1_reg && !mode1_reg;

    // new key sorts before entry i; an empty slot counts as larger
    always_comb
    begin
        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            ins_lt[i] = !valid_reg[i] || ({dsum, key1_reg} < {dist_reg[i], key_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg  <= sqx[2*POS_W-1:0];
        sqy_reg  <= sqy[2*POS_W-1:0];
        key1_reg <= cand_key;
        tag1_reg <= pick_i_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_NEIGHBOURS; g++)
        begin : g_slot
            if (g == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (insert && ins_lt[0] && (nk_reg != '0))
                    begin
                        dist_reg[0] <= dsum;
                        key_reg[0]  <= key1_reg;
                    end
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        valid_reg[0] <= 1'b0;
                    end
                    else if (ctrl.clear)
                    begin
                        valid_reg[0] <= 1'b0;
                    end
                    else if (insert && ins_lt[0] && (nk_reg != '0))
                    begin
                        valid_reg[0] <= 1'b1;
                    end
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk)
                begin
                    if (insert && ins_lt[g] && (NKW'(g) < nk_reg))
                    begin
                        if (!ins_lt[g-1])
                        begin
                            dist_reg[g] <= dsum;
                            key_reg[g]  <= key1_reg;
                        end
                        else
                        begin
                            dist_reg[g] <= dist_reg[g-1];
                            key_reg[g]  <= key_reg[g-1];
                        end
                    end
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        valid_reg[g] <= 1'b0;
                    end
                    else if (ctrl.clear)
                    begin
                        valid_reg[g] <= 1'b0;
                    end
                    else if (insert && ins_lt[g] && (NKW'(g) < nk_reg))
                    begin
                        valid_reg[g] <= !ins_lt[g-1] || valid_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nk_reg        <= '0;
            cnt_reg       <= '0;
            picking_reg   <= 1'b0;
            pick_i_reg    <= '0;
            pick_done_reg <= 1'b0;
            v1_reg        <= 1'b0;
            mode1_reg     <= 1'b0;
            best_reg      <= '0;
            fbest_reg     <= '0;
        end
        else
        begin
            pick_done_reg <= 1'b0;
            v1_reg        <= ctrl.cand_valid || issue_pick;
            mode1_reg     <= picking_reg;
            if (ctrl.clear)
            begin
                nk_reg  <= nk;
                cnt_reg <= '0;
            end
            else if (insert && (cnt_reg < nk_reg))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctrl.pick_start)
            begin
                pick_i_reg <= '0;
                if (cnt_reg == '0)
                begin
                    // empty search falls back to the particle itself
                    best_reg      <= {self_x, self_y};
                    pick_done_reg <= 1'b1;
                end
                else
                begin
                    picking_reg <= 1'b1;
                end
            end
            else if (issue_pick)
            begin
                pick_i_reg <= pick_i_reg + 1'b1;
            end
            if (v1_reg && mode1_reg)
            begin
                if ((tag1_reg == '0) || (dsum < fbest_reg))
                begin
                    best_reg  <= key1_reg;
                    fbest_reg <= dsum;
                end
                if (tag1_reg == cnt_reg - 1'b1)
                begin
                    picking_reg   <= 1'b0;
                    pick_done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy      = ctrl.cand_valid || (v1_reg && !mode1_reg);
    assign pick_done = pick_done_reg;
    assign best_x    = best_reg[KEY_W-1:POS_W];
    assign best_y    = best_reg[POS_W-1:0];

endmodule

`default_nettype wire

### rtl/swarm_tail.sv
// ---------------------------------------------------------------------------
// swarm_tail
// Velocity, position, edge jump and personal-best update, sequenced over
// one shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module swarm_tail (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire swarm_pkg::tail_cfg_t cfg,
    input  wire swarm_pkg::tail_op_t  op,
    output logic                      done,
    output swarm_pkg::tail_res_t      res
);
    import swarm_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'd14;
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    logic                running_reg;
    logic [3:0]          step_reg;
    logic                done_reg;
    logic signed [65:0]  prod_reg;
    logic [31:0]         k1_reg;
    logic [31:0]         k2_reg;
    logic signed [35:0]  acc_reg;
    logic [VEL_W-1:0]    vx_reg;
    logic [VEL_W-1:0]    vy_reg;
    logic [POS_W-1:0]    nx_reg;
    logic [POS_W-1:0]    ny_reg;
    logic [DIST_W-1:0]   f_reg;
    logic [DIST_W-1:0]   fnew_reg;
    logic                improved_reg;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  sh14;
    logic signed [65:0]  sh16;
    logic signed [65:0]  sh30;
    logic signed [35:0]  term14;
    logic signed [35:0]  term16;
    logic signed [35:0]  term30;
    logic signed [35:0]  acc_sum;
    logic [VEL_W-1:0]    vel_sat;
    logic signed [35:0]  pos_sum;
    logic [POS_W-1:0]    pos_in;
    logic [POS_W-1:0]    edge_in;
    logic [POS_W-1:0]    pos_new;
    logic [DIST_W-1:0]   fsum;

    function automatic logic signed [32:0] diff33(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        return {{(32 - POS_W){d[POS_W]}}, d};
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:    begin mul_a = {17'b0, cfg.cognitive}; mul_b = {17'b0, op.r1}; end
            4'd1:    begin mul_a = {17'b0, cfg.social};    mul_b = {17'b0, op.r2}; end
            4'd2:    begin mul_a = {op.vel_x[VEL_W-1], op.vel_x}; mul_b = {17'b0, cfg.inertia}; end
            4'd3:    begin mul_a = {1'b0, k1_reg}; mul_b = diff33(op.best_x, op.pos_x); end
            4'd4:    begin mul_a = {1'b0, k2_reg}; mul_b = diff33(op.nb_x, op.pos_x); end
            4'd5:    begin mul_a = {op.vel_y[VEL_W-1], op.vel_y}; mul_b = {17'b0, cfg.inertia}; end
            4'd6:    begin mul_a = {1'b0, k1_reg}; mul_b = diff33(op.best_y, op.pos_y); end
            4'd7:    begin mul_a = {1'b0, k2_reg}; mul_b = diff33(op.nb_y, op.pos_y); end
            4'd8:    begin mul_a = {vx_reg[VEL_W-1], vx_reg}; mul_b = {17'b0, cfg.step}; end
            4'd9:    begin mul_a = {vy_reg[VEL_W-1], vy_reg}; mul_b = {17'b0, cfg.step}; end
            4'd10:   begin mul_a = diff33(nx_reg, op.tgt_x); mul_b = mul_a; end
            4'd11:   begin mul_a = diff33(ny_reg, op.tgt_y); mul_b = mul_a; end
            4'd12:   begin mul_a = diff33(op.best_x, op.tgt_x); mul_b = mul_a; end
            4'd13:   begin mul_a = diff33(op.best_y, op.tgt_y); mul_b = mul_a; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        sh14    = prod_reg >>> 14;
        sh16    = prod_reg >>> 16;
        sh30    = prod_reg >>> 30;
        term14  = sh14[35:0];
        term16  = sh16[35:0];
        term30  = sh30[35:0];
        acc_sum = acc_reg + term30;
        if (acc_sum > SAT_MAX)
        begin
            vel_sat = 32'h7FFF_FFFF;
        end
        else if (acc_sum < SAT_MIN)
        begin
            vel_sat = 32'h8000_0000;
        end
        else
        begin
            vel_sat = acc_sum[VEL_W-1:0];
        end
        pos_in  = (step_reg == 4'd9) ? op.pos_x : op.pos_y;
        edge_in = (step_reg == 4'd9) ? cfg.width : cfg.height;
        pos_sum = $signed({11'b0, pos_in}) + term16;
        // edge jump: past the far edge wraps to zero, below zero to the edge
        if (pos_sum > $signed({11'b0, edge_in}))
        begin
            pos_new = '0;
        end
        else if (pos_sum < 36'sd0)
        begin
            pos_new = edge_in;
        end
        else
        begin
            pos_new = pos_sum[POS_W-1:0];
        end
        fsum = f_reg + prod_reg[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (step_reg)
            4'd1:    k1_reg   <= prod_reg[31:0];
            4'd2:    k2_reg   <= prod_reg[31:0];
            4'd3:    acc_reg  <= term14;
            4'd4:    acc_reg  <= acc_sum;
            4'd5:    vx_reg   <= vel_sat;
            4'd6:    acc_reg  <= term14;
            4'd7:    acc_reg  <= acc_sum;
            4'd8:    vy_reg   <= vel_sat;
            4'd9:    nx_reg   <= pos_new;
            4'd10:   ny_reg   <= pos_new;
            4'd11:   f_reg    <= prod_reg[DIST_W-1:0];
            4'd12:   fnew_reg <= fsum;
            4'd13:   f_reg    <= prod_reg[DIST_W-1:0];
            4'd14:   improved_reg <= fnew_reg < fsum;
            default: acc_reg  <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            step_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                step_reg    <= '0;
            end
            else if (running_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done         = done_reg;
    assign res.pos_x    = nx_reg;
    assign res.pos_y    = ny_reg;
    assign res.vel_x    = vx_reg;
    assign res.vel_y    = vy_reg;
    assign res.improved = improved_reg;

endmodule

`default_nettype wire

### rtl/swarm_particle_update_knn.sv
// ---------------------------------------------------------------------------
// swarm_particle_update_knn
// Local-best particle swarm: loads particles and updates one particle per
// request using its nearest neighbours and a target point.
//
//   channel   signals                        direction  transfer
//   request   start, busy, request           in         start && !busy
//   result    done, result                   out        done, one cycle
//   config    cfg_write, cfg_addr, cfg_data  in         cfg_write
//
// A load request writes the particle memory directly and leaves busy low.
// In an update the scan reads one stored particle per cycle from the
// single memory read port, the target pass walks the neighbour list one
// entry per cycle and the tail runs 15 steps on one shared multiplier.
// Reset clears control only; memory contents are undefined until loaded.
// The result cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module swarm_particle_update_knn #(
    parameter int MAX_PARTICLES  = swarm_pkg::DEF_MAX_PARTICLES,
    parameter int MAX_NEIGHBOURS = swarm_pkg::DEF_MAX_NEIGHBOURS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire swarm_pkg::request_t              request,
    output logic                                  done,
    output swarm_pkg::result_t                    result,
    input  wire logic                             cfg_write,
    input  wire logic [swarm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [swarm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import swarm_pkg::*;

    localparam int AW  = $clog2(MAX_PARTICLES);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int NKW = $clog2(MAX_NEIGHBOURS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SELF, S_SCAN, S_DRAIN, S_PICK, S_TAIL} state_t;

    state_t            state_reg;
    request_t          req_reg;
    entry_t            self_reg;
    logic              first_reg;
    logic              issued_reg;
    logic [CW-1:0]     j_reg;
    logic              done_reg;
    result_t           result_reg;

    logic [PCNT_W-1:0] particle_count_reg;
    logic [NCNT_W-1:0] neighbour_count_reg;
    logic [GAIN_W-1:0] inertia_reg;
    logic [GAIN_W-1:0] cognitive_reg;
    logic [GAIN_W-1:0] social_reg;
    logic [POS_W-1:0]  width_reg;
    logic [POS_W-1:0]  height_reg;
    logic [GAIN_W-1:0] step_reg;

    logic              idx_ok;
    logic              accept;
    logic              load_we;
    logic [CW-1:0]     pc;
    logic [NKW-1:0]    nk;
    logic              issue;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    entry_t            mem_rdata;
    knn_ctrl_t         knn_ctrl;
    logic              knn_busy;
    logic              pick_done;
    logic [POS_W-1:0]  nb_x;
    logic [POS_W-1:0]  nb_y;
    logic              tail_start;
    logic              tail_done;
    tail_cfg_t         tail_cfg;
    tail_op_t          tail_op;
    tail_res_t         tail_res;

    assign busy    = (state_reg != S_IDLE);
    assign idx_ok  = int'(request.part_idx) < MAX_PARTICLES;
    assign accept  = start && !busy && idx_ok;
    assign load_we = accept && (request.cmd == CMD_LOAD);

    always_comb
    begin
        if (int'(particle_count_reg) < MAX_PARTICLES)
        begin
            pc = CW'(particle_count_reg);
        end
        else
        begin
            pc = CW'(MAX_PARTICLES);
        end
        if (neighbour_count_reg == '0)
        begin
            nk = NKW'(1);
        end
        else if (int'(neighbour_count_reg) > MAX_NEIGHBOURS)
        begin
            nk = NKW'(MAX_NEIGHBOURS);
        end
        else
        begin
            nk = NKW'(neighbour_count_reg);
        end
        if (int'(nk) > int'(pc))
        begin
            nk = NKW'(pc);
        end
    end

    assign issue = (state_reg == S_SCAN) && (j_reg < pc);

    // memory port selection
    always_comb
    begin
        mem_re    = (state_reg == S_SELF) || issue;
        mem_raddr = (state_reg == S_SELF) ? AW'(req_reg.part_idx) : AW'(j_reg);
        if (load_we)
        begin
            mem_we          = 1'b1;
            mem_waddr       = AW'(request.part_idx);
            mem_wdata.pos_x  = request.load_pos_x;
            mem_wdata.pos_y  = request.load_pos_y;
            mem_wdata.vel_x  = request.load_vel_x;
            mem_wdata.vel_y  = request.load_vel_y;
            mem_wdata.best_x = request.load_pos_x;
            mem_wdata.best_y = request.load_pos_y;
        end
        else
        begin
            mem_we           = tail_done;
            mem_waddr        = AW'(req_reg.part_idx);
            mem_wdata.pos_x  = tail_res.pos_x;
            mem_wdata.pos_y  = tail_res.pos_y;
            mem_wdata.vel_x  = tail_res.vel_x;
            mem_wdata.vel_y  = tail_res.vel_y;
            mem_wdata.best_x = tail_res.improved ? tail_res.pos_x : self_reg.best_x;
            mem_wdata.best_y = tail_res.improved ? tail_res.pos_y : self_reg.best_y;
        end
    end

    assign knn_ctrl.clear      = (state_reg == S_SELF);
    assign knn_ctrl.cand_valid = issued_reg;
    assign knn_ctrl.pick_start = (state_reg == S_DRAIN) && !issued_reg && !knn_busy;
    assign tail_start          = (state_reg == S_PICK) && pick_done;

    assign tail_cfg.inertia   = inertia_reg;
    assign tail_cfg.cognitive = cognitive_reg;
    assign tail_cfg.social    = social_reg;
    assign tail_cfg.width     = width_reg;
    assign tail_cfg.height    = height_reg;
    assign tail_cfg.step      = step_reg;

    assign tail_op.pos_x  = self_reg.pos_x;
    assign tail_op.pos_y  = self_reg.pos_y;
    assign tail_op.vel_x  = self_reg.vel_x;
    assign tail_op.vel_y  = self_reg.vel_y;
    assign tail_op.best_x = self_reg.best_x;
    assign tail_op.best_y = self_reg.best_y;
    assign tail_op.nb_x   = nb_x;
    assign tail_op.nb_y   = nb_y;
    assign tail_op.r1     = req_reg.rand_cognitive;
    assign tail_op.r2     = req_reg.rand_social;
    assign tail_op.tgt_x  = req_reg.target_x;
    assign tail_op.tgt_y  = req_reg.target_y;

    swarm_store #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    swarm_knn #(
        .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
    ) u_knn (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (knn_ctrl),
        .nk        (nk),
        .self_x    (self_reg.pos_x),
        .self_y    (self_reg.pos_y),
        .cand_x    (mem_rdata.pos_x),
        .cand_y    (mem_rdata.pos_y),
        .tgt_x     (req_reg.target_x),
        .tgt_y     (req_reg.target_y),
        .busy      (knn_busy),
        .pick_done (pick_done),
        .best_x    (nb_x),
        .best_y    (nb_y)
    );

    swarm_tail u_tail (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tail_start),
        .cfg   (tail_cfg),
        .op    (tail_op),
        .done  (tail_done),
        .res   (tail_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_count_reg  <= RST_PARTICLE_COUNT;
            neighbour_count_reg <= RST_NEIGHBOUR_COUNT;
            inertia_reg         <= RST_INERTIA_WEIGHT;
            cognitive_reg       <= RST_COGNITIVE_GAIN;
            social_reg          <= RST_SOCIAL_GAIN;
            width_reg           <= RST_WORLD_WIDTH;
            height_reg          <= RST_WORLD_HEIGHT;
            step_reg            <= RST_TIME_STEP;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                REG_PARTICLE_COUNT:  particle_count_reg  <= cfg_data[PCNT_W-1:0];
                REG_NEIGHBOUR_COUNT: neighbour_count_reg <= cfg_data[NCNT_W-1:0];
                REG_INERTIA_WEIGHT:  inertia_reg         <= cfg_data[GAIN_W-1:0];
                REG_COGNITIVE_GAIN:  cognitive_reg       <= cfg_data[GAIN_W-1:0];
                REG_SOCIAL_GAIN:     social_reg          <= cfg_data[GAIN_W-1:0];
                REG_WORLD_WIDTH:     width_reg           <= cfg_data[POS_W-1:0];
                REG_WORLD_HEIGHT:    height_reg          <= cfg_data[POS_W-1:0];
                REG_TIME_STEP:       step_reg            <= cfg_data[GAIN_W-1:0];
                default:             step_reg            <= step_reg;
            endcase
        end
    end

    // payload captures
    always_ff @(posedge clk)
    begin
        if (accept && (request.cmd == CMD_UPDATE))
        begin
            req_reg <= request;
        end
        if (first_reg)
        begin
            self_reg <= mem_rdata;
        end
        if (tail_done)
        begin
            result_reg.out_index     <= req_reg.part_idx;
            result_reg.new_pos_x     <= tail_res.pos_x;
            result_reg.new_pos_y     <= tail_res.pos_y;
            result_reg.new_vel_x     <= tail_res.vel_x;
            result_reg.new_vel_y     <= tail_res.vel_y;
            result_reg.best_improved <= tail_res.improved;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            first_reg  <= 1'b0;
            issued_reg <= 1'b0;
            j_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            first_reg  <= 1'b0;
            issued_reg <= issue;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (request.cmd == CMD_UPDATE))
                    begin
                        state_reg <= S_SELF;
                    end
                end
                S_SELF:
                begin
                    // own entry arrives in the first scan cycle
                    first_reg <= 1'b1;
                    j_reg     <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (knn_ctrl.pick_start)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    if (pick_done)
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    if (tail_done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_update_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.cmd == CMD_UPDATE)) |=> busy)
        else $error("update request not followed by busy");

    a_tail_state : assert property (@(posedge clk) disable iff (!rst_n)
        tail_done |-> (state_reg == S_TAIL))
        else $error("tail finished outside tail state");

    a_pick_state : assert property (@(posedge clk) disable iff (!rst_n)
        pick_done |-> (state_reg == S_PICK))
        else $error("neighbour pick finished outside pick state");

    a_no_write_clash : assert property (@(posedge clk) disable iff (!rst_n)
        !(load_we && tail_done))
        else $error("load and write-back in the same cycle");
`endif

endmodule

`default_nettype wire

### tb/tb_swarm_particle_update_knn.sv
// ---------------------------------------------------------------------------
// tb_swarm_particle_update_knn
// Self-checking bench for the swarm particle block: every particle is loaded
// first, then a directed table and random load/update requests run under
// several register settings; a local predictor or a fixed value checks each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_swarm_particle_update_knn;
    import swarm_pkg::*;

    localparam int NPART      = DEF_MAX_PARTICLES;
    localparam int NNEIGH     = DEF_MAX_NEIGHBOURS;
    localparam int IDLE_LIMIT = 20000;
    localparam int NPHASE     = 9;
    localparam int PHASE_REQS = 135;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    request_t              request;
    logic                  done;
    result_t               result;
    logic                  cfg_write;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    swarm_particle_update_knn u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // mirrored registers
    logic [PCNT_W-1:0] m_pcount;
    logic [NCNT_W-1:0] m_ncount;
    logic [GAIN_W-1:0] m_inertia, m_cog, m_soc, m_step;
    logic [POS_W-1:0]  m_width, m_height;

    // mirrored particle memory
    logic [POS_W-1:0] s_pos_x [NPART];
    logic [POS_W-1:0] s_pos_y [NPART];
    logic [VEL_W-1:0] s_vel_x [NPART];
    logic [VEL_W-1:0] s_vel_y [NPART];
    logic [POS_W-1:0] s_best_x [NPART];
    logic [POS_W-1:0] s_best_y [NPART];

    result_t   pending_results[$];
    stim_row_t dir_rows[$];
    int        errors;
    int        idle_cycles;
    bit        allow_gaps;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic bit key_less(longint d1, longint k1, longint d2, longint k2);
        return (d1 < d2) || (d1 == d2 && k1 < k2);
    endfunction

    function automatic longint next_vel(longint v, longint pos, longint pb, longint sb,
                                        longint r1, longint r2);
        longint t;
        t = (v * longint'(m_inertia)) >>> 14;
        t += (longint'(m_cog) * r1 * (pb - pos)) >>> 30;
        t += (longint'(m_soc) * r2 * (sb - pos)) >>> 30;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t;
    endfunction

    function automatic longint edge_jump(longint p, longint edge_pos);
        if (p > edge_pos) return 0;
        if (p < 0) return edge_pos;
        return p;
    endfunction

    // applies one accepted request to the mirror; returns 1 with the update result, 0 for a load
    function automatic bit swarm_step(request_t r, output result_t res);
        int     idx, pc, nk, cnt, at;
        longint px, py, tx, ty, sbx, sby, vx, vy, nx, ny, d, k, fb, fv, cx, cy;
        longint near_d [NNEIGH];
        longint near_k [NNEIGH];
        bit     improved;
        idx = r.part_idx;
        res = '0;
        if (r.cmd == CMD_LOAD) begin
            s_pos_x[idx]  = r.load_pos_x;
            s_pos_y[idx]  = r.load_pos_y;
            s_vel_x[idx]  = r.load_vel_x;
            s_vel_y[idx]  = r.load_vel_y;
            s_best_x[idx] = r.load_pos_x;
            s_best_y[idx] = r.load_pos_y;
            return 1'b0;
        end
        px = s_pos_x[idx];
        py = s_pos_y[idx];
        tx = r.target_x;
        ty = r.target_y;
        pc = (m_pcount < NPART) ? m_pcount : NPART;
        nk = (m_ncount != 0) ? m_ncount : 1;
        if (nk > NNEIGH) nk = NNEIGH;
        if (nk > pc) nk = pc;
        cnt = 0;
        for (int j = 0; j < pc; j++) begin
            d = sq_dist(s_pos_x[j], s_pos_y[j], px, py);
            k = {14'd0, s_pos_x[j], s_pos_y[j]};
            if (cnt == nk && !key_less(d, k, near_d[cnt-1], near_k[cnt-1])) continue;
            at = (cnt < nk) ? cnt : nk - 1;
            while (at > 0 && key_less(d, k, near_d[at-1], near_k[at-1])) begin
                near_d[at] = near_d[at-1];
                near_k[at] = near_k[at-1];
                at--;
            end
            near_d[at] = d;
            near_k[at] = k;
            if (cnt < nk) cnt++;
        end
        // empty search keeps the particle's own position
        sbx = px;
        sby = py;
        if (cnt > 0) begin
            sbx = near_k[0] >> 25;
            sby = near_k[0] & 64'h1FFFFFF;
            fb = sq_dist(sbx, sby, tx, ty);
            for (int i = 1; i < cnt; i++) begin
                cx = near_k[i] >> 25;
                cy = near_k[i] & 64'h1FFFFFF;
                fv = sq_dist(cx, cy, tx, ty);
                if (fv < fb) begin
                    fb = fv;
                    sbx = cx;
                    sby = cy;
                end
            end
        end
        vx = next_vel(longint'($signed(s_vel_x[idx])), px, s_best_x[idx], sbx,
                      r.rand_cognitive, r.rand_social);
        vy = next_vel(longint'($signed(s_vel_y[idx])), py, s_best_y[idx], sby,
                      r.rand_cognitive, r.rand_social);
        nx = edge_jump(px + ((vx * longint'(m_step)) >>> 16), m_width);
        ny = edge_jump(py + ((vy * longint'(m_step)) >>> 16), m_height);
        s_vel_x[idx] = vx[VEL_W-1:0];
        s_vel_y[idx] = vy[VEL_W-1:0];
        s_pos_x[idx] = nx[POS_W-1:0];
        s_pos_y[idx] = ny[POS_W-1:0];
        improved = sq_dist(nx, ny, tx, ty) < sq_dist(s_best_x[idx], s_best_y[idx], tx, ty);
        if (improved) begin
            s_best_x[idx] = s_pos_x[idx];
            s_best_y[idx] = s_pos_y[idx];
        end
        res.out_index     = idx[IDX_W-1:0];
        res.new_pos_x     = nx[POS_W-1:0];
        res.new_pos_y     = ny[POS_W-1:0];
        res.new_vel_x     = vx[VEL_W-1:0];
        res.new_vel_y     = vy[VEL_W-1:0];
        res.best_improved = improved;
        return 1'b1;
    endfunction

    // result checker
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (result.out_index !== want.out_index) begin
                    $display("%0t: out_index exp %0d got %0d", $time,
                             want.out_index, result.out_index);
                    errors++;
                end
                if (result.new_pos_x !== want.new_pos_x) begin
                    $display("%0t: new_pos_x exp %h got %h", $time,
                             want.new_pos_x, result.new_pos_x);
                    errors++;
                end
                if (result.new_pos_y !== want.new_pos_y) begin
                    $display("%0t: new_pos_y exp %h got %h", $time,
                             want.new_pos_y, result.new_pos_y);
                    errors++;
                end
                if (result.new_vel_x !== want.new_vel_x) begin
                    $display("%0t: new_vel_x exp %h got %h", $time,
                             want.new_vel_x, result.new_vel_x);
                    errors++;
                end
                if (result.new_vel_y !== want.new_vel_y) begin
                    $display("%0t: new_vel_y exp %h got %h", $time,
                             want.new_vel_y, result.new_vel_y);
                    errors++;
                end
                if (result.best_improved !== want.best_improved) begin
                    $display("%0t: best_improved exp %b got %b", $time,
                             want.best_improved, result.best_improved);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_write) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(request_t r, bit typed, result_t want);
        result_t predicted;
        if (allow_gaps && ($urandom_range(3) == 0)) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start   = 1'b1;
        request = r;
        while (busy) @(negedge clk);
        @(posedge clk);
        if (swarm_step(r, predicted))
            pending_results.insert(pending_results.size(), typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        while (busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        cfg_write = 1'b1;
        cfg_addr  = addr;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (addr)
            REG_PARTICLE_COUNT:  m_pcount  = value[PCNT_W-1:0];
            REG_NEIGHBOUR_COUNT: m_ncount  = value[NCNT_W-1:0];
            REG_INERTIA_WEIGHT:  m_inertia = value[GAIN_W-1:0];
            REG_COGNITIVE_GAIN:  m_cog     = value[GAIN_W-1:0];
            REG_SOCIAL_GAIN:     m_soc     = value[GAIN_W-1:0];
            REG_WORLD_WIDTH:     m_width   = value[POS_W-1:0];
            REG_WORLD_HEIGHT:    m_height  = value[POS_W-1:0];
            REG_TIME_STEP:       m_step    = value[GAIN_W-1:0];
            default:             m_step    = m_step;
        endcase
    endtask

    function automatic logic [POS_W-1:0] rand_pos(logic [POS_W-1:0] edge_pos);
        if ($urandom_range(7) == 0) return POS_W'($urandom());
        return POS_W'($urandom_range(edge_pos, 0));
    endfunction

    function automatic logic [VEL_W-1:0] rand_vel();
        case ($urandom_range(7))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom_range(2097152) - 1048576;
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.cmd            = ($urandom_range(3) == 0) ? CMD_LOAD : CMD_UPDATE;
        r.part_idx       = IDX_W'($urandom_range(NPART - 1));
        r.load_pos_x     = rand_pos(m_width);
        r.load_pos_y     = rand_pos(m_height);
        r.load_vel_x     = rand_vel();
        r.load_vel_y     = rand_vel();
        r.rand_cognitive = GAIN_W'($urandom());
        r.rand_social    = GAIN_W'($urandom());
        r.target_x       = rand_pos(m_width);
        r.target_y       = rand_pos(m_height);
        return r;
    endfunction

    function automatic void add_row(logic cmd, int idx, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                    logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy,
                                    logic [GAIN_W-1:0] r1, logic [GAIN_W-1:0] r2,
                                    logic [POS_W-1:0] tx, logic [POS_W-1:0] ty);
        stim_row_t row;
        row.req   = {cmd, idx[IDX_W-1:0], x, y, vx, vy, r1, r2, tx, ty};
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] cfg [NPHASE][8];
        request_t r;
        stim_row_t row;
        errors      = 0;
        idle_cycles = 0;
        allow_gaps  = 1'b1;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_write   = 1'b0;
        cfg_addr    = '0;
        cfg_data    = '0;
        m_pcount  = RST_PARTICLE_COUNT;
        m_ncount  = RST_NEIGHBOUR_COUNT;
        m_inertia = RST_INERTIA_WEIGHT;
        m_cog     = RST_COGNITIVE_GAIN;
        m_soc     = RST_SOCIAL_GAIN;
        m_width   = RST_WORLD_WIDTH;
        m_height  = RST_WORLD_HEIGHT;
        m_step    = RST_TIME_STEP;

        // all particles at the origin, so every search is a full tie
        for (int i = 0; i < NPART; i++) add_row(CMD_LOAD, i, 0, 0, 0, 0, 0, 0, 0, 0);
        row.req   = {CMD_UPDATE, 7'd0, 25'd0, 25'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF,
                     25'h1FFFFFF, 25'h1FFFFFF};
        row.typed = 1'b1;
        row.want  = '0;
        dir_rows.insert(dir_rows.size(), row);
        add_row(CMD_LOAD, 127, 25'h1FFFFFF, 25'h1FFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                16'hFFFF, 16'hFFFF, 25'h1FFFFFF, 25'h1FFFFFF);
        add_row(CMD_LOAD, 1, 0, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        add_row(CMD_LOAD, 2, 25'h0AAAAAA, 25'h1555555, 32'h55555555, 32'hAAAAAAAA,
                16'h5555, 16'hAAAA, 25'h1555555, 25'h0AAAAAA);
        add_row(CMD_LOAD, 3, 25'd6553600, 25'd3276800, 32'h00010000, 32'hFFFF0000,
                0, 0, 0, 0);
        // particle outside the searched count, driven past the far edge
        add_row(CMD_UPDATE, 127, 0, 0, 0, 0, 0, 0, 0, 0);
        // large negative velocity, position falls below zero
        add_row(CMD_UPDATE, 1, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 25'h1FFFFFF, 25'h1FFFFFF);
        add_row(CMD_UPDATE, 2, 0, 0, 0, 0, 16'hFFFF, 0, 25'd100, 25'd100);
        add_row(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 16'hFFFF, 25'd16000000, 25'd200);
        add_row(CMD_UPDATE, 3, 0, 0, 0, 0, 16'h8000, 16'h8000, 25'd6553600, 25'd3276800);
        add_row(CMD_UPDATE, 3, 0, 0, 0, 0, 16'h1234, 16'hFEDC, 0, 0);
        add_row(CMD_UPDATE, 0, 0, 0, 0, 0, 16'h0001, 16'h0001, 25'd1, 25'd1);
        add_row(CMD_UPDATE, 127, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 25'd500, 25'd8000000);

        // settings per phase: count, neighbours, w, c1, c2, width, height, step
        cfg[0] = '{100, 10, 14746, 24576, 24576, 16384000, 16384000, 655};
        cfg[1] = '{128, 16, 65535, 65535, 65535, 25'h1FFFFFF, 25'h1FFFFFF, 65535};
        cfg[2] = '{1, 0, 0, 0, 0, 0, 0, 0};
        cfg[3] = '{0, 5, 14746, 24576, 24576, 16384000, 16384000, 6553};
        cfg[4] = '{255, 31, 20000, 30000, 10000, 8000000, 12000000, 30000};
        cfg[5] = '{16, 16, 65535, 0, 65535, 1000000, 1000000, 65535};
        cfg[6] = '{2, 1, 16384, 16384, 16384, 16384000, 25'd65536, 1000};
        for (int p = 7; p < NPHASE; p++)
            cfg[p] = '{$urandom_range(255), $urandom_range(31), $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(65535), $urandom(),
                       $urandom(), $urandom_range(65535)};

        repeat (10) @(posedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed,
                                           dir_rows[i].want);

        for (int p = 1; p < NPHASE; p++) begin
            wait_idle();
            for (int a = 0; a < 8; a++) write_reg(CFG_ADDR_W'(a), cfg[p][a]);
            if (p == NPHASE - 1) allow_gaps = 1'b0;
            for (int n = 0; n < PHASE_REQS; n++) begin
                r = rand_request();
                send_request(r, 1'b0, '0);
            end
        end
        start = 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
